// ----- src/pcse_pkg.sv -----
package pcse_pkg;

  localparam logic [2:0] OP_WRITE    = 3'd0;
  localparam logic [2:0] OP_WAVE     = 3'd1;
  localparam logic [2:0] OP_LENGTH   = 3'd2;
  localparam logic [2:0] OP_ENVELOPE = 3'd3;
  localparam logic [2:0] OP_SWEEP    = 3'd4;

  localparam logic [2:0] REG_SWEEP    = 3'd0;
  localparam logic [2:0] REG_DUTY_LEN = 3'd1;
  localparam logic [2:0] REG_ENVELOPE = 3'd2;
  localparam logic [2:0] REG_PERIOD_L = 3'd3;
  localparam logic [2:0] REG_PERIOD_H = 3'd4;

  localparam int NUM_REGS = 5;

  localparam logic [11:0] PERIOD_SPAN   = 12'd2048;
  localparam logic [3:0]  SWEEP_DEFAULT = 4'd8;
  localparam logic [3:0]  VOLUME_MAX    = 4'd15;
  localparam logic [5:0]  LENGTH_LAST   = 6'd63;

  typedef logic [7:0] byte_t;

  function automatic logic duty_bit(input logic [1:0] duty, input logic [2:0] step);
    logic [7:0] pattern;
    begin
      case (duty)
        2'd0: pattern = 8'b1111_1110;
        2'd1: pattern = 8'b0111_1110;
        2'd2: pattern = 8'b1100_1100;
        default: pattern = 8'b1100_0000;
      endcase
      duty_bit = pattern[step];
    end
  endfunction

  function automatic logic [11:0] sweep_target(input logic [10:0] shadow,
                                               input logic [2:0] slope,
                                               input logic decrease);
    logic [10:0] delta;
    begin
      delta = shadow >> slope;
      if (decrease) begin
        sweep_target = {1'b0, shadow} - {1'b0, delta};
      end else begin
        sweep_target = {1'b0, shadow} + {1'b0, delta};
      end
    end
  endfunction

endpackage

// ----- src/pulse_channel_with_sweep_envelope.sv -----
// Square-wave channel with envelope, length counter and frequency sweep.
// An accepted input beat is held in the input register; its result beat in
// the result register. Throughput: one event per cycle unless out_stall holds
// the result; the state update is a single pass of logic between the two registers.
// Reset (rst, synchronous): register bytes, volume, timers, sweep shadow,
// phase and duty step clear to zero; the channel is off and no beat is held.
module pulse_channel_with_sweep_envelope (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  operation,
  input  logic [2:0]  reg_index,
  input  pcse_pkg::byte_t write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  sample,
  output logic        channel_on,
  output logic [10:0] wavelength
);
  import pcse_pkg::*;

  logic        s1_valid;
  logic [2:0]  op_q;
  logic [2:0]  idx_q;
  byte_t       data_q;

  byte_t       cb [NUM_REGS];
  logic        enabled;
  logic [3:0]  volume;
  logic [2:0]  env_timer;
  logic [10:0] shadow;
  logic [3:0]  sweep_timer;
  logic        sweep_active;
  logic [11:0] phase;
  logic [2:0]  duty_step;

  byte_t       cb_next [NUM_REGS];
  logic        enabled_next;
  logic [3:0]  volume_next;
  logic [2:0]  env_timer_next;
  logic [10:0] shadow_next;
  logic [3:0]  sweep_timer_next;
  logic        sweep_active_next;
  logic [11:0] phase_next;
  logic [2:0]  duty_step_next;

  logic        advance;
  logic        load_in;

  logic [10:0] cur_wl;
  logic [2:0]  pace;
  logic [11:0] phase_inc;
  logic [12:0] phase_sum;
  logic [6:0]  len_inc;
  logic [2:0]  env_dec;
  logic [3:0]  swp_dec;
  logic [11:0] np1;
  logic [11:0] np2;

  assign advance  = !out_valid || !out_stall;
  assign load_in  = !s1_valid || advance;
  assign in_stall = s1_valid && !advance;

  assign cur_wl    = {cb[REG_PERIOD_H][2:0], cb[REG_PERIOD_L]};
  assign pace      = cb[REG_SWEEP][6:4];
  assign phase_inc = phase + 12'd1;
  assign phase_sum = {1'b0, phase_inc} + {2'b00, cur_wl};
  assign len_inc   = {1'b0, cb[REG_DUTY_LEN][5:0]} + 7'd1;
  assign env_dec   = (env_timer != 3'd0) ? env_timer - 3'd1 : env_timer;
  assign swp_dec   = (sweep_timer != 4'd0) ? sweep_timer - 4'd1 : sweep_timer;
  assign np1       = sweep_target(shadow, cb[REG_SWEEP][2:0], cb[REG_SWEEP][3]);
  assign np2       = sweep_target(np1[10:0], cb[REG_SWEEP][2:0], cb[REG_SWEEP][3]);

  always_comb begin
    for (int i = 0; i < NUM_REGS; i++) begin
      cb_next[i] = cb[i];
    end
    enabled_next      = enabled;
    volume_next       = volume;
    env_timer_next    = env_timer;
    shadow_next       = shadow;
    sweep_timer_next  = sweep_timer;
    sweep_active_next = sweep_active;
    phase_next        = phase;
    duty_step_next    = duty_step;
    if (s1_valid) begin
      case (op_q)
        OP_WRITE: begin
          case (idx_q)
            REG_SWEEP:    cb_next[REG_SWEEP]    = data_q;
            REG_DUTY_LEN: cb_next[REG_DUTY_LEN] = data_q;
            REG_ENVELOPE: cb_next[REG_ENVELOPE] = data_q;
            REG_PERIOD_L: cb_next[REG_PERIOD_L] = data_q;
            REG_PERIOD_H: begin
              cb_next[REG_PERIOD_H] = data_q;
              if (data_q[7]) begin
                enabled_next      = 1'b1;
                env_timer_next    = cb[REG_ENVELOPE][2:0];
                volume_next       = cb[REG_ENVELOPE][7:4];
                shadow_next       = {data_q[2:0], cb[REG_PERIOD_L]};
                sweep_timer_next  = (pace == 3'd0) ? SWEEP_DEFAULT : {1'b0, pace};
                sweep_active_next = (pace != 3'd0) || (cb[REG_SWEEP][2:0] != 3'd0);
              end
            end
            default: ;
          endcase
        end
        OP_WAVE: begin
          if (phase_sum >= {1'b0, PERIOD_SPAN}) begin
            phase_next     = '0;
            duty_step_next = duty_step + 3'd1;
          end else begin
            phase_next = phase_inc;
          end
        end
        OP_LENGTH: begin
          if (cb[REG_PERIOD_H][6]) begin
            cb_next[REG_DUTY_LEN] = {cb[REG_DUTY_LEN][7:6], len_inc[5:0]};
            if (cb[REG_DUTY_LEN][5:0] == LENGTH_LAST) begin
              enabled_next = 1'b0;
            end
          end
        end
        OP_ENVELOPE: begin
          if (cb[REG_ENVELOPE][2:0] != 3'd0) begin
            env_timer_next = env_dec;
            if (env_dec == 3'd0) begin
              env_timer_next = cb[REG_ENVELOPE][2:0];
              if (cb[REG_ENVELOPE][3]) begin
                if (volume != VOLUME_MAX) begin
                  volume_next = volume + 4'd1;
                end
              end else if (volume != 4'd0) begin
                volume_next = volume - 4'd1;
              end
            end
          end
        end
        OP_SWEEP: begin
          sweep_timer_next = swp_dec;
          if (swp_dec == 4'd0) begin
            sweep_timer_next = (pace == 3'd0) ? SWEEP_DEFAULT : {1'b0, pace};
            if (sweep_active && pace != 3'd0) begin
              if (np1[11]) begin
                enabled_next = 1'b0;
              end else begin
                cb_next[REG_PERIOD_L] = np1[7:0];
                cb_next[REG_PERIOD_H] = {cb[REG_PERIOD_H][7:3], np1[10:8]};
                shadow_next           = np1[10:0];
                if (np2[11]) begin
                  enabled_next = 1'b0;
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load_in) begin
      s1_valid <= in_valid;
    end
    if (load_in) begin
      op_q   <= operation;
      idx_q  <= reg_index;
      data_q <= write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cb[i] <= '0;
      end
      enabled      <= 1'b0;
      volume       <= '0;
      env_timer    <= '0;
      shadow       <= '0;
      sweep_timer  <= '0;
      sweep_active <= 1'b0;
      phase        <= '0;
      duty_step    <= '0;
      out_valid    <= 1'b0;
    end else if (advance) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cb[i] <= cb_next[i];
      end
      enabled      <= enabled_next;
      volume       <= volume_next;
      env_timer    <= env_timer_next;
      shadow       <= shadow_next;
      sweep_timer  <= sweep_timer_next;
      sweep_active <= sweep_active_next;
      phase        <= phase_next;
      duty_step    <= duty_step_next;
      out_valid    <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      sample     <= duty_bit(cb_next[REG_DUTY_LEN][7:6], duty_step_next) ? volume_next : 4'd0;
      channel_on <= enabled_next;
      wavelength <= {cb_next[REG_PERIOD_H][2:0], cb_next[REG_PERIOD_L]};
    end
  end

endmodule

// ----- tb/pulse_channel_with_sweep_envelope_tb.sv -----
`timescale 1ns / 100ps

module pulse_channel_with_sweep_envelope_tb;
  import pcse_pkg::*;

  localparam logic [2:0] OP_UNUSED  = 3'd7;
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int RANDOM_BEATS = 1250;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SHOWN_ERRORS = 10;

  // duty pattern per duty code, bit n is the level at duty position n
  localparam logic [3:0][7:0] DUTY_WAVE = {8'b1100_0000, 8'b1100_1100,
                                           8'b0111_1110, 8'b1111_1110};

  typedef struct packed {
    logic [3:0]  sample;
    logic        enabled;
    logic [10:0] wl;
  } tone_t;

  typedef struct packed {
    logic [2:0] op;
    logic [2:0] idx;
    byte_t      data;
    logic       typed;
    tone_t      want;
  } script_row_t;

  localparam tone_t NO_TONE = '0;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  operation;
  logic [2:0]  reg_index;
  byte_t       write_data;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  sample;
  logic        channel_on;
  logic [10:0] wavelength;

  logic  row_typed;
  tone_t row_want;
  logic  quiet;
  int    mismatches;
  int    cycle_count;
  tone_t tone_q[$];

  byte_t       chan_regs [NUM_REGS];
  logic        chan_en;
  logic [3:0]  chan_vol;
  logic [2:0]  env_count;
  logic [10:0] sweep_shadow;
  logic [3:0]  sweep_count;
  logic        sweep_on;
  logic [11:0] phase;
  logic [2:0]  duty_pos;

  script_row_t script [22] = '{
    '{OP_WAVE,     REG_SWEEP,    8'h00, 1'b1, '{4'd0, 1'b0, 11'd0}},
    '{OP_UNUSED,   REG_SWEEP,    8'hFF, 1'b1, '{4'd0, 1'b0, 11'd0}},
    '{OP_WRITE,    REG_UNUSED,   8'hFF, 1'b1, '{4'd0, 1'b0, 11'd0}},
    '{OP_WRITE,    REG_PERIOD_L, 8'hFF, 1'b1, '{4'd0, 1'b0, 11'd255}},
    '{OP_WRITE,    REG_PERIOD_H, 8'h07, 1'b1, '{4'd0, 1'b0, 11'd2047}},
    '{OP_WRITE,    REG_DUTY_LEN, 8'hBF, 1'b1, '{4'd0, 1'b0, 11'd2047}},
    '{OP_WRITE,    REG_ENVELOPE, 8'hF9, 1'b1, '{4'd0, 1'b0, 11'd2047}},
    '{OP_WRITE,    REG_SWEEP,    8'h11, 1'b1, '{4'd0, 1'b0, 11'd2047}},
    '{OP_WRITE,    REG_PERIOD_H, 8'hC7, 1'b1, '{4'd0, 1'b1, 11'd2047}},
    '{OP_WAVE,     REG_SWEEP,    8'h00, 1'b0, NO_TONE},
    '{OP_WAVE,     REG_PERIOD_H, 8'hFF, 1'b0, NO_TONE},
    '{OP_ENVELOPE, REG_SWEEP,    8'h00, 1'b0, NO_TONE},
    '{OP_LENGTH,   REG_SWEEP,    8'h00, 1'b0, NO_TONE},
    '{OP_WRITE,    REG_PERIOD_H, 8'h87, 1'b0, NO_TONE},
    '{OP_SWEEP,    REG_SWEEP,    8'h00, 1'b0, NO_TONE},
    '{OP_WRITE,    REG_SWEEP,    8'h19, 1'b0, NO_TONE},
    '{OP_WRITE,    REG_PERIOD_H, 8'hBD, 1'b0, NO_TONE},
    '{OP_SWEEP,    REG_SWEEP,    8'h00, 1'b0, NO_TONE},
    '{OP_WRITE,    REG_ENVELOPE, 8'h01, 1'b0, NO_TONE},
    '{OP_ENVELOPE, REG_SWEEP,    8'h00, 1'b0, NO_TONE},
    '{OP_WRITE,    REG_ENVELOPE, 8'h00, 1'b0, NO_TONE},
    '{OP_ENVELOPE, REG_SWEEP,    8'h00, 1'b0, NO_TONE}
  };

  pulse_channel_with_sweep_envelope dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .reg_index  (reg_index),
    .write_data (write_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample     (sample),
    .channel_on (channel_on),
    .wavelength (wavelength)
  );

  always #10 clk = ~clk;

  function automatic logic [11:0] swept_period();
    logic [10:0] delta;
    delta = sweep_shadow >> chan_regs[REG_SWEEP][2:0];
    if (chan_regs[REG_SWEEP][3]) begin
      return {1'b0, sweep_shadow} - {1'b0, delta};
    end
    return {1'b0, sweep_shadow} + {1'b0, delta};
  endfunction

  function automatic tone_t advance_channel(input logic [2:0] op, input logic [2:0] idx,
                                            input byte_t data);
    logic [10:0] wl;
    logic [2:0]  pace;
    logic [11:0] np;
    logic [6:0]  len;
    tone_t       r;
    wl = {chan_regs[REG_PERIOD_H][2:0], chan_regs[REG_PERIOD_L]};
    case (op)
      OP_WRITE: begin
        if (idx < NUM_REGS) begin
          chan_regs[idx] = data;
          if (idx == REG_PERIOD_H && data[7]) begin
            pace = chan_regs[REG_SWEEP][6:4];
            chan_en = 1'b1;
            env_count = chan_regs[REG_ENVELOPE][2:0];
            chan_vol = chan_regs[REG_ENVELOPE][7:4];
            sweep_shadow = {chan_regs[REG_PERIOD_H][2:0], chan_regs[REG_PERIOD_L]};
            sweep_count = (pace == 3'd0) ? SWEEP_DEFAULT : {1'b0, pace};
            sweep_on = (pace != 3'd0) || (chan_regs[REG_SWEEP][2:0] != 3'd0);
          end
        end
      end
      OP_WAVE: begin
        phase = phase + 12'd1;
        if (int'(phase) + int'(wl) >= 2048) begin
          phase = '0;
          duty_pos = duty_pos + 3'd1;
        end
      end
      OP_LENGTH: begin
        if (chan_regs[REG_PERIOD_H][6]) begin
          len = {1'b0, chan_regs[REG_DUTY_LEN][5:0]} + 7'd1;
          if (len == 7'd64) begin
            len = '0;
            chan_en = 1'b0;
          end
          chan_regs[REG_DUTY_LEN][5:0] = len[5:0];
        end
      end
      OP_ENVELOPE: begin
        pace = chan_regs[REG_ENVELOPE][2:0];
        if (pace != 3'd0) begin
          if (env_count != 3'd0) env_count = env_count - 3'd1;
          if (env_count == 3'd0) begin
            env_count = pace;
            if (chan_regs[REG_ENVELOPE][3]) begin
              if (chan_vol != VOLUME_MAX) chan_vol = chan_vol + 4'd1;
            end else if (chan_vol != 4'd0) begin
              chan_vol = chan_vol - 4'd1;
            end
          end
        end
      end
      OP_SWEEP: begin
        pace = chan_regs[REG_SWEEP][6:4];
        if (sweep_count != 4'd0) sweep_count = sweep_count - 4'd1;
        if (sweep_count == 4'd0) begin
          sweep_count = (pace == 3'd0) ? SWEEP_DEFAULT : {1'b0, pace};
          if (sweep_on && pace != 3'd0) begin
            np = swept_period();
            if (np > 12'd2047) begin
              chan_en = 1'b0;
            end else begin
              chan_regs[REG_PERIOD_L] = np[7:0];
              chan_regs[REG_PERIOD_H][2:0] = np[10:8];
              sweep_shadow = np[10:0];
              if (swept_period() > 12'd2047) chan_en = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
    r.sample = DUTY_WAVE[chan_regs[REG_DUTY_LEN][7:6]][duty_pos] ? chan_vol : 4'd0;
    r.enabled = chan_en;
    r.wl = {chan_regs[REG_PERIOD_H][2:0], chan_regs[REG_PERIOD_L]};
    return r;
  endfunction

  task automatic clear_channel();
    for (int i = 0; i < NUM_REGS; i++) chan_regs[i] = '0;
    chan_en = 1'b0;
    chan_vol = '0;
    env_count = '0;
    sweep_shadow = '0;
    sweep_count = '0;
    sweep_on = 1'b0;
    phase = '0;
    duty_pos = '0;
  endtask

  task automatic report_mismatch(input string what, input tone_t want, input tone_t got);
    mismatches++;
    if (mismatches <= SHOWN_ERRORS) begin
      $display("%s: sample exp %0d got %0d, channel_on exp %0d got %0d, wavelength exp %0d got %0d",
               what, want.sample, got.sample, want.enabled, got.enabled, want.wl, got.wl);
    end
  endtask

  // check the result beat first, then predict the accepted input beat
  always @(posedge clk) begin
    tone_t got;
    tone_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got = '{sample, channel_on, wavelength};
        if (tone_q.size() == 0) begin
          report_mismatch("unexpected result beat", NO_TONE, got);
        end else begin
          want = tone_q.pop_front();
          if (got.sample !== want.sample || got.enabled !== want.enabled ||
              got.wl !== want.wl) begin
            report_mismatch("result mismatch", want, got);
          end
        end
      end
      if (in_valid && !in_stall) begin
        want = advance_channel(operation, reg_index, write_data);
        if (row_typed) want = row_want;
        tone_q.push_back(want);
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !quiet && ($urandom_range(0, 99) < 10);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_beat(input logic [2:0] op, input logic [2:0] idx, input byte_t data,
                           input logic typed, input tone_t want);
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    reg_index <= idx;
    write_data <= data;
    row_typed <= typed;
    row_want <= want;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tone_q.size() != 0) @(negedge clk);
  endtask

  // mostly ticks and register writes biased toward audible settings, some noise
  task automatic pick_random_beat(output logic [2:0] op, output logic [2:0] idx,
                                  output byte_t data);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    idx = 3'($urandom_range(0, 7));
    data = 8'($urandom);
    if (roll < 28) begin
      op = OP_WAVE;
    end else if (roll < 40) begin
      op = OP_LENGTH;
    end else if (roll < 52) begin
      op = OP_ENVELOPE;
    end else if (roll < 64) begin
      op = OP_SWEEP;
    end else if (roll < 95) begin
      op = OP_WRITE;
      idx = 3'($urandom_range(0, NUM_REGS - 1));
      if (roll >= 88) begin
        idx = REG_PERIOD_H;
        data[7] = 1'b1;
      end
      case (idx)
        REG_PERIOD_L: begin
          if ($urandom_range(0, 1) == 0) data = 8'($urandom_range(224, 255));
        end
        REG_PERIOD_H: begin
          if ($urandom_range(0, 2) != 0) data[2:0] = 3'b111;
        end
        REG_DUTY_LEN: begin
          if ($urandom_range(0, 1) == 0) data[5:0] = 6'($urandom_range(56, 63));
        end
        default: ;
      endcase
    end else if (roll < 98) begin
      op = 3'($urandom_range(5, 7));
    end else begin
      op = OP_WRITE;
      idx = 3'($urandom_range(5, 7));
    end
  endtask

  initial begin
    logic [2:0] op;
    logic [2:0] idx;
    byte_t      data;
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    operation = OP_WRITE;
    reg_index = REG_SWEEP;
    write_data = '0;
    out_stall = 1'b0;
    row_typed = 1'b0;
    row_want = NO_TONE;
    quiet = 1'b0;
    mismatches = 0;
    cycle_count = 0;
    clear_channel();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      send_beat(script[i].op, script[i].idx, script[i].data, script[i].typed, script[i].want);
    end
    hold_until_drained();

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      quiet = (n >= 500 && n < 800);
      if (n == 900) hold_until_drained();
      pick_random_beat(op, idx, data);
      send_beat(op, idx, data, 1'b0, NO_TONE);
    end
    quiet = 1'b0;

    hold_until_drained();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && tone_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
